FILE: rtl/murmur3_32_stream_hash_defines.svh
// ----------------------------------------------------------------------------
// murmur3_32_stream_hash assertion macros
// Concurrent assertion wrappers on clk, disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef MURMUR3_32_STREAM_HASH_DEFINES_SVH
`define MURMUR3_32_STREAM_HASH_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MM3_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MM3_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define MM3_ASSERT(lbl, prop, msg)
`define MM3_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: rtl/mm3_pkg.sv
// ----------------------------------------------------------------------------
// mm3_pkg
// Constants and types shared by the MurmurHash3 x86_32 stream hash.
// ----------------------------------------------------------------------------
package mm3_pkg;

	localparam logic [31:0] C1 = 32'hcc9e2d51;
	localparam logic [31:0] C2 = 32'h1b873593;
	localparam logic [31:0] FOLD_ADD = 32'he6546b64;
	localparam logic [31:0] F1 = 32'h85ebca6b;
	localparam logic [31:0] F2 = 32'hc2b2ae35;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam logic [QCNT_W-1:0] Q_FULL = QCNT_W'(QDEPTH);
	localparam logic [QPTR_W-1:0] Q_LAST = QPTR_W'(QDEPTH - 1);

	typedef enum logic [1:0] {
		KIND_FULL,
		KIND_TAIL,
		KIND_NONE
	} item_kind_t;

	typedef struct packed {
		logic [31:0] key;
		item_kind_t  kind;
		logic        last;
		logic [2:0]  nbytes;
	} item_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              push;
		logic              pop;
	} qstat_t;

endpackage

FILE: rtl/mm3_front.sv
// ----------------------------------------------------------------------------
// mm3_front
// Accepts words, classifies full/tail/empty, masks tail bytes, mixes the key.
// ----------------------------------------------------------------------------
module mm3_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [31:0]     data_word,
	input  logic [2:0]      valid_bytes,
	input  logic            last_word,
	input  logic            q_ready,
	output logic            q_push,
	output mm3_pkg::item_t  q_item,
	output logic            busy
);

	logic                 valid_s1;
	logic [31:0]          prod_s1;
	mm3_pkg::item_kind_t  kind_s1;
	logic                 last_s1;
	logic [2:0]           nbytes_s1;

	logic                 accept;
	logic [2:0]           nb_sat;
	logic [2:0]           nb_use;
	mm3_pkg::item_kind_t  kind_in;
	logic [31:0]          mask;
	logic [31:0]          rot;

	always_comb begin
		nb_sat = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
		nb_use = last_word ? nb_sat : 3'd4;
		if (nb_use == 3'd4) begin
			kind_in = mm3_pkg::KIND_FULL;
		end else if (nb_use == 3'd0) begin
			kind_in = mm3_pkg::KIND_NONE;
		end else begin
			kind_in = mm3_pkg::KIND_TAIL;
		end
		unique case (nb_use)
			3'd1:    mask = 32'h0000_00ff;
			3'd2:    mask = 32'h0000_ffff;
			3'd3:    mask = 32'h00ff_ffff;
			default: mask = 32'hffff_ffff;
		endcase
	end

	assign q_push   = valid_s1 & q_ready;
	assign in_ready = ~valid_s1 | q_ready;
	assign accept   = in_valid & in_ready;
	assign busy     = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1   <= (data_word & mask) * mm3_pkg::C1;
			kind_s1   <= kind_in;
			last_s1   <= last_word;
			nbytes_s1 <= nb_use;
		end
	end

	assign rot = {prod_s1[16:0], prod_s1[31:17]};

	always_comb begin
		q_item.key    = rot * mm3_pkg::C2;
		q_item.kind   = kind_s1;
		q_item.last   = last_s1;
		q_item.nbytes = nbytes_s1;
	end

endmodule

FILE: rtl/mm3_fifo.sv
// ----------------------------------------------------------------------------
// mm3_fifo
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module mm3_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mm3_pkg::item_t  push_item,
	output logic            ready,
	input  logic            pop,
	output logic            valid,
	output mm3_pkg::item_t  head,
	output mm3_pkg::qstat_t stat
);

	mm3_pkg::item_t                 mem_q [mm3_pkg::QDEPTH];
	logic [mm3_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [mm3_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [mm3_pkg::QCNT_W-1:0]     count_q;
	logic                           do_push;
	logic                           do_pop;

	assign ready   = (count_q != mm3_pkg::Q_FULL);
	assign valid   = (count_q != '0);
	assign do_push = push & ready;
	assign do_pop  = pop & valid;
	assign head    = mem_q[rd_ptr_q];

	always_comb begin
		stat.count = count_q;
		stat.push  = do_push;
		stat.pop   = do_pop;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == mm3_pkg::Q_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == mm3_pkg::Q_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/mm3_back.sv
// ----------------------------------------------------------------------------
// mm3_back
// Folds mixed keys into the running hash (a tail key is only XORed in), then runs the fmix finalizer.
// ----------------------------------------------------------------------------
module mm3_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [31:0]     seed,
	input  logic            q_valid,
	input  mm3_pkg::item_t  q_head,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [31:0]     hash_value
);

	logic [31:0] hash_q;
	logic [31:0] total_q;
	logic        mid_q;

	logic        v_s1, v_s2, v_s3, out_valid_q;
	logic [31:0] fin_s1, fin_s2, fin_s3, res_q;

	logic [31:0] h_cur, t_cur, t_next, x, rot, folded, h_last;
	logic        adv1, adv2, adv3, free1, free2, free3, pop_last;
	logic [31:0] a1, a2;

	always_comb begin
		h_cur  = mid_q ? hash_q : seed;
		t_cur  = mid_q ? total_q : 32'd0;
		t_next = t_cur + 32'(q_head.nbytes);
		x      = h_cur ^ q_head.key;
		rot    = {x[18:0], x[31:19]};
		folded = {rot[29:0], 2'b00} + rot + mm3_pkg::FOLD_ADD;
		unique case (q_head.kind)
			mm3_pkg::KIND_FULL: h_last = folded;
			mm3_pkg::KIND_TAIL: h_last = x;
			default:            h_last = h_cur;
		endcase
	end

	assign free3    = ~out_valid_q | out_ready;
	assign adv3     = v_s3 & free3;
	assign free2    = ~v_s3 | adv3;
	assign adv2     = v_s2 & free2;
	assign free1    = ~v_s2 | adv2;
	assign adv1     = v_s1 & free1;
	assign q_pop    = q_valid & (~q_head.last | ~v_s1 | adv1);
	assign pop_last = q_pop & q_head.last;

	assign a1 = fin_s1 ^ {16'd0, fin_s1[31:16]};
	assign a2 = fin_s2 ^ {13'd0, fin_s2[31:13]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q       <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				mid_q <= ~q_head.last;
			end
			v_s1        <= pop_last | (v_s1 & ~adv1);
			v_s2        <= adv1 | (v_s2 & ~adv2);
			v_s3        <= adv2 | (v_s3 & ~adv3);
			out_valid_q <= adv3 | (out_valid_q & ~out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && !q_head.last) begin
			hash_q  <= folded;
			total_q <= t_next;
		end
		if (pop_last) begin
			fin_s1 <= h_last ^ t_next;
		end
		if (adv1) begin
			fin_s2 <= a1 * mm3_pkg::F1;
		end
		if (adv2) begin
			fin_s3 <= a2 * mm3_pkg::F2;
		end
		if (adv3) begin
			res_q <= fin_s3 ^ {16'd0, fin_s3[31:16]};
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = res_q;

endmodule

FILE: rtl/murmur3_32_stream_hash.sv
// ----------------------------------------------------------------------------
// murmur3_32_stream_hash: MurmurHash3 x86_32 over a stream of 32-bit words
// Path: the last word passes the front register, the queue, fin_s1, fin_s2, fin_s3 and res_q.
// Throughput: one word per cycle unless the queue or out_ready back-pressure holds the flow; set by the hash loop fold.
// Reset: arst_n clears the seed to 0, the queue and all valid flags at once.
// ----------------------------------------------------------------------------
`include "murmur3_32_stream_hash_defines.svh"

module murmur3_32_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash_value
);

	logic [31:0]      seed_q;
	logic             q_push, q_ready, q_valid, q_pop, front_busy;
	mm3_pkg::item_t   push_item, q_head;
	mm3_pkg::qstat_t  q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_wr_en) begin
			seed_q <= cfg_wr_data;
		end
	end

	mm3_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_word   (data_word),
		.valid_bytes (valid_bytes),
		.last_word   (last_word),
		.q_ready     (q_ready),
		.q_push      (q_push),
		.q_item      (push_item),
		.busy        (front_busy)
	);

	mm3_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.ready     (q_ready),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head),
		.stat      (q_stat)
	);

	mm3_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed       (seed_q),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value)
	);

	`MM3_ASSERT_NEVER(a_q_over, q_stat.count > mm3_pkg::Q_FULL, "queue count over depth")
	`MM3_ASSERT(a_q_count, q_stat.push && !q_stat.pop |=> q_stat.count == $past(q_stat.count) + 1'b1, "queue count lost a push")
	`MM3_ASSERT(a_stall, !in_ready |-> front_busy && !q_ready, "input stalled without a held item")

endmodule

FILE: bench/murmur3_32_stream_hash_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// murmur3_32_stream_hash_tb
// Self-checking bench for the MurmurHash3 x86_32 stream hasher. Words are sent
// as messages over the input handshake, a local hash model predicts each
// finished hash, and every result is checked in order. It covers directed
// corner cases, seed writes, receiver back-pressure and random traffic.
// ----------------------------------------------------------------------------
module murmur3_32_stream_hash_tb;

	localparam logic [31:0] K_C1  = 32'hcc9e2d51;
	localparam logic [31:0] K_C2  = 32'h1b873593;
	localparam logic [31:0] K_ADD = 32'he6546b64;
	localparam logic [31:0] K_F1  = 32'h85ebca6b;
	localparam logic [31:0] K_F2  = 32'hc2b2ae35;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES = 200;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] data_word;
	logic [2:0]  valid_bytes;
	logic        last_word;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] hash_value;

	logic [31:0] pending_hashes[$];
	logic [31:0] seed_model = 32'h0;
	logic [31:0] run_hash = 32'h0;
	logic [31:0] run_len = 32'h0;
	logic        in_message = 1'b0;

	int fail_count = 0;
	int cycle_count = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	murmur3_32_stream_hash DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_word  (data_word),
		.valid_bytes(valid_bytes),
		.last_word  (last_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] scramble(input logic [31:0] k);
		logic [31:0] t;
		t = k * K_C1;
		t = rotl(t, 15);
		return t * K_C2;
	endfunction

	function automatic logic [31:0] absorb(input logic [31:0] h, input logic [31:0] k);
		logic [31:0] t;
		t = h ^ scramble(k);
		t = rotl(t, 13);
		return t * 32'd5 + K_ADD;
	endfunction

	function automatic logic [31:0] avalanche(input logic [31:0] h);
		logic [31:0] t;
		t = h ^ (h >> 16);
		t = t * K_F1;
		t = t ^ (t >> 13);
		t = t * K_F2;
		return t ^ (t >> 16);
	endfunction

	// hash model, advanced on each accepted word and seed write
	always @(posedge clk) begin : hash_model
		int nb;
		logic [31:0] h;
		if (arst_n) begin
			if (cfg_wr_en)
				seed_model = cfg_wr_data;
			if (in_valid && in_ready) begin
				if (!in_message) begin
					run_hash = seed_model;
					run_len = 32'h0;
				end
				if (!last_word) begin
					run_hash = absorb(run_hash, data_word);
					run_len = run_len + 32'd4;
					in_message = 1'b1;
				end else begin
					nb = (valid_bytes > 3'd4) ? 4 : int'(valid_bytes);
					h = run_hash;
					if (nb == 4)
						h = absorb(h, data_word);
					else if (nb != 0)
						h = h ^ scramble(data_word & ((32'h1 << (8 * nb)) - 32'h1));
					run_len = run_len + 32'(nb);
					pending_hashes.push_back(avalanche(h ^ run_len));
					run_hash = 32'h0;
					run_len = 32'h0;
					in_message = 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : hash_check
		logic [31:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_hashes.size() == 0) begin
				$display("%0t unexpected hash %08h, none pending", $time, hash_value);
				fail_count++;
			end else begin
				want = pending_hashes.pop_front();
				if (hash_value !== want) begin
					$display("%0t hash mismatch: expected %08h, actual %08h",
						$time, want, hash_value);
					fail_count++;
				end
			end
		end
	end

	// receiver: random stalls, or a long hold-off when requested
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	task automatic send_word(input logic [31:0] w, input logic [2:0] nb, input logic lw);
		if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
		end
		in_valid <= 1'b1;
		data_word <= w;
		valid_bytes <= nb;
		last_word <= lw;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_message(input int words);
		for (int i = 0; i < words - 1; i++)
			send_word($urandom, 3'($urandom_range(7)), 1'b0);
		send_word($urandom, 3'($urandom_range(7)), 1'b1);
	endtask

	// wait on the clock first so the model has taken the last accepted word
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_hashes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_seed(input logic [31:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic test_tail_lengths();
		send_word(32'h0, 3'd0, 1'b1);
		send_word(32'hffffffff, 3'd1, 1'b1);
		send_word(32'h12345678, 3'd2, 1'b1);
		send_word(32'hffffffff, 3'd3, 1'b1);
		send_word(32'h0, 3'd4, 1'b1);
		send_word(32'hffffffff, 3'd4, 1'b1);
		send_word(32'hdeadbeef, 3'd5, 1'b1);
		send_word(32'h80000001, 3'd6, 1'b1);
		send_word(32'hffffffff, 3'd7, 1'b1);
		send_word(32'hffffffff, 3'd0, 1'b0);
		send_word(32'h0, 3'd7, 1'b0);
		send_word(32'h01020304, 3'd3, 1'b1);
		settle();
	endtask

	task automatic test_seed_extremes();
		set_seed(32'hffffffff);
		send_word(32'h0, 3'd0, 1'b1);
		send_word(32'hffffffff, 3'd4, 1'b1);
		send_word(32'haaaaaaaa, 3'd1, 1'b0);
		send_word(32'h55555555, 3'd2, 1'b1);
		set_seed(32'h0);
		send_word(32'h0, 3'd0, 1'b1);
		settle();
	endtask

	task automatic test_seed_mid_message();
		set_seed(32'h00000001);
		send_word(32'h61626364, 3'd4, 1'b0);
		send_word(32'h65666768, 3'd0, 1'b0);
		set_seed(32'h9747b28c);
		send_word(32'h00696a6b, 3'd3, 1'b1);
		send_word(32'h00000061, 3'd1, 1'b1);
		settle();
	endtask

	task automatic test_output_hold();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 30; i++)
			send_word($urandom, 3'($urandom_range(7)), 1'b1);
		settle();
	endtask

	task automatic test_random_traffic(input int n_words, input int snd_pct, input int rcv_pct);
		int sent;
		int len;
		set_seed($urandom);
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		sent = 0;
		while (sent < n_words) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(5, 1);
			send_message(len);
			sent += len;
		end
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 32'h0;
		in_valid = 1'b0;
		data_word = 32'h0;
		valid_bytes = 3'd0;
		last_word = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_tail_lengths();
		test_seed_extremes();
		test_seed_mid_message();
		test_output_hold();
		test_random_traffic(200, 27, 46);
		test_random_traffic(200, 46, 27);
		test_random_traffic(200, 0, 0);

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
